>>> sv/tcg_pkg.sv
// Package for the text cursor glyph sequencer: screen constants, operation
// codes, microcode word layout, status bundle and the font index function.
// No dependencies.
`default_nettype none

package tcg_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 128;
    localparam int CELL_ADVANCE  = 6;

    localparam logic [7:0] SCREEN_W = 8'(SCREEN_WIDTH);
    localparam logic [7:0] SCREEN_H = 8'(SCREEN_HEIGHT);
    localparam logic [7:0] CELL_ADV = 8'(CELL_ADVANCE);

    localparam logic [7:0] CODE_ZERO  = 8'h30;
    localparam logic [7:0] CODE_MINUS = 8'h2d;

    localparam logic [1:0] OP_SET_CURSOR = 2'd0;
    localparam logic [1:0] OP_NUMBER     = 2'd1;
    localparam logic [1:0] OP_CHAR       = 2'd2;

    localparam int NUM_DIGITS = 10;
    localparam int BIN_BITS   = 32;

    typedef logic [3:0] tcg_act_t;
    typedef logic [3:0] tcg_cond_t;
    typedef logic [3:0] tcg_pc_t;

    localparam tcg_act_t ACT_NOP        = 4'd0;
    localparam tcg_act_t ACT_WAIT       = 4'd1;
    localparam tcg_act_t ACT_SET_CURSOR = 4'd2;
    localparam tcg_act_t ACT_EMIT_CHAR  = 4'd3;
    localparam tcg_act_t ACT_LOAD       = 4'd4;
    localparam tcg_act_t ACT_EMIT_ZERO  = 4'd5;
    localparam tcg_act_t ACT_EMIT_MINUS = 4'd6;
    localparam tcg_act_t ACT_DABBLE     = 4'd7;
    localparam tcg_act_t ACT_FIND       = 4'd8;
    localparam tcg_act_t ACT_EMIT_DIGIT = 4'd9;
    localparam tcg_act_t ACT_FLUSH      = 4'd10;

    localparam tcg_cond_t C_NEVER       = 4'd0;
    localparam tcg_cond_t C_ALWAYS      = 4'd1;
    localparam tcg_cond_t C_OP_NUM      = 4'd2;
    localparam tcg_cond_t C_NOT_CHAR_OK = 4'd3;
    localparam tcg_cond_t C_NOT_ZERO    = 4'd4;
    localparam tcg_cond_t C_NOT_NEG     = 4'd5;
    localparam tcg_cond_t C_CNT_MORE    = 4'd6;
    localparam tcg_cond_t C_DIG_ZERO    = 4'd7;
    localparam tcg_cond_t C_DIG_MORE    = 4'd8;

    typedef struct packed {
        tcg_act_t  act;
        tcg_cond_t cond;
        tcg_pc_t   target;
    } tcg_ucode_t;

    typedef struct packed {
        logic op_num;
        logic char_ok;
        logic num_zero;
        logic num_neg;
        logic cnt_more;
        logic dig_zero;
        logic dig_more;
        logic stall;
    } tcg_status_t;

    function automatic logic [7:0] font_index(input logic [7:0] code);
        logic [7:0] idx;
        if (code >= 8'h20 && code <= 8'h7f)
        begin
            idx = code - 8'd32;
        end
        else if (code >= 8'hc0)
        begin
            idx = code - 8'd96;
        end
        else
        begin
            idx = 8'd85;
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> sv/tcg_if.sv
// Channel interfaces for the text cursor glyph sequencer: command in, glyph out.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface tcg_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] number;
    logic [7:0]         char_code;
    logic [7:0]         x_position;
    logic [7:0]         y_position;

    modport source (output valid, op, number, char_code, x_position, y_position,
                    input ready);
    modport sink   (input valid, op, number, char_code, x_position, y_position,
                    output ready);
endinterface

interface tcg_glyph_if;
    logic       valid;
    logic       ready;
    logic [7:0] glyph_index;
    logic [7:0] glyph_x;
    logic [7:0] glyph_y;
    logic       last;

    modport source (output valid, glyph_index, glyph_x, glyph_y, last, input ready);
    modport sink   (input valid, glyph_index, glyph_x, glyph_y, last, output ready);
endinterface

`default_nettype wire

>>> sv/tcg_ucode_rom.sv
// Microcode program of the glyph sequencer: one control word per step.
// Depends on tcg_pkg.
`default_nettype none

module tcg_ucode_rom
    import tcg_pkg::*;
(
    input  tcg_pc_t    pc,
    output tcg_ucode_t word
);

    always_comb
    begin
        unique case (pc)
            4'd0:    word = '{ACT_WAIT,       C_NEVER,       4'd0};
            4'd1:    word = '{ACT_SET_CURSOR, C_OP_NUM,      4'd4};
            4'd2:    word = '{ACT_NOP,        C_NOT_CHAR_OK, 4'd0};
            4'd3:    word = '{ACT_EMIT_CHAR,  C_ALWAYS,      4'd11};
            4'd4:    word = '{ACT_LOAD,       C_NOT_ZERO,    4'd6};
            4'd5:    word = '{ACT_EMIT_ZERO,  C_ALWAYS,      4'd11};
            4'd6:    word = '{ACT_NOP,        C_NOT_NEG,     4'd8};
            4'd7:    word = '{ACT_EMIT_MINUS, C_NEVER,       4'd0};
            4'd8:    word = '{ACT_DABBLE,     C_CNT_MORE,    4'd8};
            4'd9:    word = '{ACT_FIND,       C_DIG_ZERO,    4'd9};
            4'd10:   word = '{ACT_EMIT_DIGIT, C_DIG_MORE,    4'd10};
            4'd11:   word = '{ACT_FLUSH,      C_ALWAYS,      4'd0};
            default: word = '{ACT_NOP,        C_ALWAYS,      4'd0};
        endcase
    end

endmodule

`default_nettype wire

>>> sv/tcg_datapath.sv
// Datapath of the glyph sequencer: command latch, cursor, binary to BCD shifter,
// digit pointer, pending glyph and output register. Depends on tcg_pkg, tcg_if.
`default_nettype none

module tcg_datapath
    import tcg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tcg_act_t          act,
    output tcg_status_t       status,
    tcg_cmd_if.sink           cmd,
    tcg_glyph_if.source       glyph
);

    logic [1:0]  op_reg;
    logic [31:0] num_reg;
    logic [7:0]  code_reg;
    logic [7:0]  xp_reg;
    logic [7:0]  yp_reg;
    logic [7:0]  cx_reg;
    logic [7:0]  cy_reg;
    logic [31:0] bin_reg;
    logic [39:0] bcd_reg;
    logic [4:0]  cnt_reg;
    logic [3:0]  idx_reg;

    logic        pend_valid_reg;
    logic [7:0]  pend_index_reg;
    logic [7:0]  pend_x_reg;
    logic [7:0]  pend_y_reg;

    logic        out_valid_reg;
    logic [7:0]  out_index_reg;
    logic [7:0]  out_x_reg;
    logic [7:0]  out_y_reg;
    logic        out_last_reg;

    logic        in_bounds;
    logic        x_left;
    logic [3:0]  cur_digit;
    logic        is_emit;
    logic        will_emit;
    logic [7:0]  new_code;
    logic        out_free;
    logic        stall;
    logic        fire;
    logic        push_pend;
    logic [39:0] bcd_adj;
    logic [31:0] mag;

    assign in_bounds = (cx_reg <= SCREEN_W) && (cy_reg <= SCREEN_H);
    assign x_left    = cx_reg < SCREEN_W;
    assign cur_digit = bcd_reg[{idx_reg, 2'b00} +: 4];
    assign mag       = num_reg[31] ? (~num_reg + 32'd1) : num_reg;
    assign out_free  = !out_valid_reg || glyph.ready;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ?
                                (bcd_reg[i*4 +: 4] + 4'd3) : bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        is_emit   = 1'b0;
        will_emit = 1'b0;
        new_code  = code_reg;
        unique case (act)
            ACT_EMIT_CHAR:
            begin
                is_emit   = 1'b1;
                will_emit = in_bounds;
            end
            ACT_EMIT_ZERO:
            begin
                is_emit   = 1'b1;
                will_emit = in_bounds;
                new_code  = CODE_ZERO;
            end
            ACT_EMIT_MINUS:
            begin
                is_emit   = 1'b1;
                will_emit = in_bounds;
                new_code  = CODE_MINUS;
            end
            ACT_EMIT_DIGIT:
            begin
                is_emit   = 1'b1;
                will_emit = in_bounds && x_left;
                new_code  = CODE_ZERO + {4'd0, cur_digit};
            end
            default:
            begin
                is_emit   = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        unique case (act)
            ACT_WAIT:  stall = !cmd.valid;
            ACT_FLUSH: stall = pend_valid_reg && !out_free;
            default:   stall = is_emit && will_emit && pend_valid_reg && !out_free;
        endcase
    end

    assign fire      = !stall;
    assign push_pend = fire && pend_valid_reg &&
                       ((is_emit && will_emit) || (act == ACT_FLUSH));

    assign cmd.ready = (act == ACT_WAIT);

    assign status.op_num   = (op_reg == OP_NUMBER);
    assign status.char_ok  = (op_reg == OP_CHAR) && (code_reg != 8'd0) && x_left &&
                             (cy_reg <= SCREEN_H);
    assign status.num_zero = (num_reg == 32'd0);
    assign status.num_neg  = num_reg[31];
    assign status.cnt_more = (cnt_reg != 5'(BIN_BITS - 1));
    assign status.dig_zero = (cur_digit == 4'd0);
    assign status.dig_more = x_left && (idx_reg != 4'd0);
    assign status.stall    = stall;

    // Command latch and number conversion registers
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            unique case (act)
                ACT_WAIT:
                begin
                    op_reg   <= cmd.op;
                    num_reg  <= $unsigned(cmd.number);
                    code_reg <= cmd.char_code;
                    xp_reg   <= cmd.x_position;
                    yp_reg   <= cmd.y_position;
                end
                ACT_LOAD:
                begin
                    bin_reg <= mag;
                    bcd_reg <= '0;
                    cnt_reg <= '0;
                    idx_reg <= 4'(NUM_DIGITS - 1);
                end
                ACT_DABBLE:
                begin
                    bcd_reg <= {bcd_adj[38:0], bin_reg[31]};
                    bin_reg <= {bin_reg[30:0], 1'b0};
                    cnt_reg <= cnt_reg + 5'd1;
                end
                ACT_FIND:
                begin
                    if (cur_digit == 4'd0 && idx_reg != 4'd0)
                    begin
                        idx_reg <= idx_reg - 4'd1;
                    end
                end
                ACT_EMIT_DIGIT:
                begin
                    if (x_left && idx_reg != 4'd0)
                    begin
                        idx_reg <= idx_reg - 4'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
        end
        else if (fire)
        begin
            unique case (act)
                ACT_SET_CURSOR:
                begin
                    if (op_reg == OP_SET_CURSOR && xp_reg <= SCREEN_W &&
                        yp_reg <= SCREEN_H)
                    begin
                        cx_reg <= xp_reg;
                        cy_reg <= yp_reg;
                    end
                end
                ACT_EMIT_CHAR, ACT_EMIT_ZERO, ACT_EMIT_MINUS:
                begin
                    cx_reg <= cx_reg + CELL_ADV;
                end
                ACT_EMIT_DIGIT:
                begin
                    if (x_left)
                    begin
                        cx_reg <= cx_reg + CELL_ADV;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Pending glyph: hold the newest glyph until the next one or the flush marks last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (is_emit && will_emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (act == ACT_FLUSH)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && is_emit && will_emit)
        begin
            pend_index_reg <= font_index(new_code);
            pend_x_reg     <= cx_reg;
            pend_y_reg     <= cy_reg;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push_pend)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (glyph.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_pend)
        begin
            out_index_reg <= pend_index_reg;
            out_x_reg     <= pend_x_reg;
            out_y_reg     <= pend_y_reg;
            out_last_reg  <= (act == ACT_FLUSH);
        end
    end

    assign glyph.valid       = out_valid_reg;
    assign glyph.glyph_index = out_index_reg;
    assign glyph.glyph_x     = out_x_reg;
    assign glyph.glyph_y     = out_y_reg;
    assign glyph.last        = out_last_reg;

endmodule

`default_nettype wire

>>> sv/text_cursor_glyph_sequencer_core.sv
// Top level of the text cursor glyph sequencer: step counter, jump logic,
// microcode ROM and datapath. Depends on tcg_pkg, tcg_if, tcg_ucode_rom, tcg_datapath.
//
//   channel | dir | payload                                          | transfer
//   cmd     | in  | op, number, char_code, x_position, y_position    | valid & ready
//   glyph   | out | glyph_index, glyph_x, glyph_y, last              | valid & ready
//
// One command at a time. A number other than zero takes 32 BCD shift steps, one scan
// step per leading zero digit plus one and one step per digit, fewer at the right edge.
// Glyphs leave through one output register; a glyph is held in the pending register
// until the next glyph or the flush so that last can be set, and the program stalls in
// place while a held glyph must move into the output register and it is full.
// Reset clears the cursor to column 0, row 0 and the program to its wait step.
`default_nettype none

module text_cursor_glyph_sequencer_core
    import tcg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tcg_cmd_if.sink      cmd,
    tcg_glyph_if.source  glyph
);

    tcg_pc_t     pc_reg;
    tcg_pc_t     pc_next;
    tcg_ucode_t  word;
    tcg_status_t status;
    logic        take_jump;

    tcg_ucode_rom u_rom (
        .pc   (pc_reg),
        .word (word)
    );

    tcg_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .act    (word.act),
        .status (status),
        .cmd    (cmd),
        .glyph  (glyph)
    );

    always_comb
    begin
        unique case (word.cond)
            C_NEVER:       take_jump = 1'b0;
            C_ALWAYS:      take_jump = 1'b1;
            C_OP_NUM:      take_jump = status.op_num;
            C_NOT_CHAR_OK: take_jump = !status.char_ok;
            C_NOT_ZERO:    take_jump = !status.num_zero;
            C_NOT_NEG:     take_jump = !status.num_neg;
            C_CNT_MORE:    take_jump = status.cnt_more;
            C_DIG_ZERO:    take_jump = status.dig_zero;
            C_DIG_MORE:    take_jump = status.dig_more;
            default:       take_jump = 1'b1;
        endcase
    end

    always_comb
    begin
        if (status.stall)
        begin
            pc_next = pc_reg;
        end
        else if (take_jump)
        begin
            pc_next = word.target;
        end
        else
        begin
            pc_next = pc_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire
